// ===== src/sm3_pkg.sv =====
// sm3 package: constants and round helper functions
package sm3_pkg;

  localparam logic [31:0] T_LO = 32'h79cc4519;
  localparam logic [31:0] T_HI = 32'h7a879d8a;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [31:0] IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef logic [31:0] word_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  // control from the top level to the compression core
  typedef struct packed {
    logic start;
  } cmp_ctl_t;

endpackage

// ===== src/sm3_core.sv =====
// sm3 compression core: 64 rounds, one per cycle, message window in registers loaded from a memory
module sm3_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sm3_pkg::cmp_ctl_t    ctl,
  input  sm3_pkg::word_t       cv_in [8],
  // message words, read from the block buffer by word index
  output logic [3:0]           msg_addr,
  input  sm3_pkg::word_t       msg_word,
  output logic                 busy,
  output logic                 done,
  output sm3_pkg::word_t       cv_out [8]
);
  import sm3_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_ROUND, S_DONE} state_t;

  state_t      state_r;
  logic [4:0]  ld_r;       // load counter, window fill 0..16
  logic [5:0]  rnd_r;
  word_t       r_r [8];
  word_t       w_r [16];   // rolling expansion window

  word_t wj, wj4, tj, a12, ss1, ss2, ff, gg, tt1, tt2, nw;

  assign msg_addr = ld_r[3:0];
  assign busy = (state_r != S_IDLE);

  always_comb begin
    wj  = w_r[rnd_r[3:0]];
    wj4 = w_r[4'(rnd_r[3:0] + 4'd4)];
    tj  = (rnd_r < 6'd16) ? T_LO : T_HI;
    a12 = rotl(r_r[0], 5'd12);
    ss1 = rotl(a12 + r_r[4] + rotl(tj, rnd_r[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (rnd_r < 6'd16) begin
      ff = r_r[0] ^ r_r[1] ^ r_r[2];
      gg = r_r[4] ^ r_r[5] ^ r_r[6];
    end else begin
      ff = (r_r[0] & r_r[1]) | (r_r[0] & r_r[2]) | (r_r[1] & r_r[2]);
      gg = (r_r[4] & r_r[5]) | (~r_r[4] & r_r[6]);
    end
    tt1 = ff + r_r[3] + ss2 + (wj ^ wj4);
    tt2 = gg + r_r[7] + ss1 + wj;
    nw  = perm1(wj ^ w_r[4'(rnd_r[3:0] + 4'd7)] ^ rotl(w_r[4'(rnd_r[3:0] + 4'd13)], 5'd15))
          ^ rotl(w_r[4'(rnd_r[3:0] + 4'd3)], 5'd7) ^ w_r[4'(rnd_r[3:0] + 4'd10)];
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      ld_r    <= '0;
      rnd_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (ctl.start) begin
            state_r <= S_LOAD;
            ld_r    <= '0;
            for (int i = 0; i < 8; i++) r_r[i] <= cv_in[i];
          end
        end
        S_LOAD: begin
          // memory read data for address ld_r-1 arrives this cycle
          if (ld_r != 5'd0) w_r[4'(ld_r - 5'd1)] <= msg_word;
          ld_r <= ld_r + 5'd1;
          if (ld_r == 5'd16) begin
            state_r <= S_ROUND;
            rnd_r   <= '0;
          end
        end
        S_ROUND: begin
          r_r[3] <= r_r[2];
          r_r[2] <= rotl(r_r[1], 5'd9);
          r_r[1] <= r_r[0];
          r_r[0] <= tt1;
          r_r[7] <= r_r[6];
          r_r[6] <= rotl(r_r[5], 5'd19);
          r_r[5] <= r_r[4];
          r_r[4] <= perm0(tt2);
          w_r[rnd_r[3:0]] <= nw;
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= S_DONE;
        end
        S_DONE: begin
          for (int i = 0; i < 8; i++) cv_out[i] <= cv_in[i] ^ r_r[i];
          done    <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/sm3_stream_hash.sv =====
// sm3 stream hash top level: byte gathering, padding and digest output
// Computes the SM3 hash of a byte stream. A message byte (in_kind 0) that
// completes a 64-byte block runs the block through the compression core:
// window load from the block buffer memory (16 reads), 64 rounds at one
// round per cycle, a chaining update and a handoff, during all of which
// in_stall is high. A finish beat (in_kind 1) writes the padding one byte
// per cycle into the block buffer, zeros up to byte 55 and then the bit
// length as two words, compresses one or two blocks, then presents eight
// digest beats, word 0 first, out_last on word 7; the block then starts a
// fresh message from the initial value. The block buffer is a 16 x 32-bit
// memory with a registered read, the chaining value sits in eight registers.
module sm3_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last
);
  import sm3_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_COMP, S_PAD, S_LEN, S_FCOMP, S_OUT
  } state_t;

  state_t       state_r;
  logic [5:0]   fill_r;       // bytes held in the block buffer
  logic [54:0]  blocks_r;     // full blocks compressed
  logic [5:0]   pad_ptr_r;    // padding write pointer
  logic [5:0]   fin_fill_r;   // fill at finish, for the length field
  logic         two_r;        // finish needs an extra block
  logic [2:0]   oidx_r;
  word_t        cv_r [8];

  // block buffer: 16 words, byte-writable, one registered read port
  word_t        buf_mem [16];
  word_t        rd_q;
  logic         wr_en;
  logic [3:0]   wr_addr;
  logic [3:0]   wr_be;
  word_t        wr_data;

  cmp_ctl_t     ctl;
  logic [3:0]   msg_addr;
  logic         core_busy, core_done;
  word_t        cv_new [8];
  logic [63:0]  bit_len;

  // the full-block finish case starts its compression here
  logic fstart;
  assign fstart = (state_r == S_FCOMP) && two_r && !core_busy && !core_done;

  // core start is the OR of the two sources
  cmp_ctl_t ctl_q;
  always_comb begin
    ctl_q = ctl;
    ctl_q.start = ctl.start | fstart;
  end

  assign bit_len = {blocks_r, 9'd0} + {55'd0, fin_fill_r, 3'd0};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int b = 0; b < 4; b++)
        if (wr_be[b]) buf_mem[wr_addr][8*b +: 8] <= wr_data[8*b +: 8];
    end
    rd_q <= buf_mem[msg_addr];
  end

  sm3_core u_core (
    .clk, .rst_n, .ctl(ctl_q), .cv_in(cv_r), .msg_addr, .msg_word(rd_q),
    .busy(core_busy), .done(core_done), .cv_out(cv_new)
  );

  // byte lane of a big-endian position within its word
  function automatic logic [3:0] lane(input logic [1:0] p);
    return 4'b1000 >> p;
  endfunction

  always_comb begin
    wr_en = 1'b0;
    wr_addr = '0;
    wr_be = '0;
    wr_data = '0;
    ctl.start = 1'b0;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          wr_en   = 1'b1;
          wr_addr = fill_r[5:2];
          wr_be   = lane(fill_r[1:0]);
          wr_data = {4{(in_kind == KIND_BYTE) ? in_data_byte : PAD_BYTE}};
          ctl.start = (in_kind == KIND_BYTE) && (fill_r == 6'd63);
        end
      end
      S_PAD: begin
        // zero fill up to the end of the block, or to the length field
        wr_en   = 1'b1;
        wr_addr = pad_ptr_r[5:2];
        wr_be   = lane(pad_ptr_r[1:0]);
        ctl.start = two_r && (pad_ptr_r == 6'd63);
      end
      S_LEN: begin
        wr_en   = 1'b1;
        wr_addr = pad_ptr_r[0] ? 4'd15 : 4'd14;
        wr_be   = 4'hF;
        wr_data = pad_ptr_r[0] ? bit_len[31:0] : bit_len[63:32];
        ctl.start = pad_ptr_r[0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= '0;
      blocks_r <= '0;
      oidx_r   <= '0;
      two_r    <= 1'b0;
      for (int i = 0; i < 8; i++) cv_r[i] <= IV[i];
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_kind == KIND_BYTE) begin
              fill_r <= fill_r + 6'd1;
              if (fill_r == 6'd63) state_r <= S_COMP;
            end else begin
              fin_fill_r <= fill_r;
              two_r      <= (fill_r > 6'd55);
              pad_ptr_r  <= fill_r + 6'd1;
              if (fill_r == 6'd55) begin
                pad_ptr_r <= 6'd0;
                state_r   <= S_LEN;
              end else if (fill_r == 6'd63) begin
                pad_ptr_r <= 6'd0;
                two_r     <= 1'b0;
                state_r   <= S_FCOMP;  // first block goes out, then zeros
              end else begin
                state_r <= S_PAD;
              end
            end
          end
        end
        S_COMP: begin
          if (core_done) begin
            cv_r     <= cv_new;
            blocks_r <= blocks_r + 55'd1;
            state_r  <= S_IDLE;
          end
        end
        S_PAD: begin
          pad_ptr_r <= pad_ptr_r + 6'd1;
          if (two_r && pad_ptr_r == 6'd63) begin
            two_r     <= 1'b0;
            pad_ptr_r <= 6'd0;
            state_r   <= S_FCOMP;
          end else if (!two_r && pad_ptr_r == 6'd55) begin
            pad_ptr_r <= 6'd0;
            state_r   <= S_LEN;
          end
        end
        S_LEN: begin
          pad_ptr_r <= pad_ptr_r + 6'd1;
          if (pad_ptr_r[0]) begin
            two_r   <= 1'b0;
            state_r <= S_FCOMP;
            fin_fill_r <= fin_fill_r;
            pad_ptr_r  <= 6'd63;  // marks the final block
          end
        end
        S_FCOMP: begin
          if (!core_busy && !core_done && pad_ptr_r == 6'd0 && fin_fill_r == 6'd63
              && !two_r) begin
            // last byte slot: start the block holding the marker byte
            two_r <= 1'b1;
          end
          if (core_done) begin
            cv_r <= cv_new;
            if (pad_ptr_r == 6'd63) begin
              oidx_r  <= '0;
              state_r <= S_OUT;
            end else begin
              two_r   <= 1'b0;   // second block holds zeros and the length
              state_r <= S_PAD;  // clear the second block
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              state_r  <= S_IDLE;
              fill_r   <= '0;
              blocks_r <= '0;
              for (int i = 0; i < 8; i++) cv_r[i] <= IV[i];
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = cv_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last        = (oidx_r == 3'd7);

endmodule

// ===== src/sm3_stream_hash_chk.sv =====
// port checker for sm3_stream_hash, bound to the top level
module sm3_stream_hash_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last
);
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_word_index == 3'd7)))
    else $error("last flag mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word))
    else $error("stalled digest changed");
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid &&
    out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest words out of order");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during digest");
endmodule

bind sm3_stream_hash sm3_stream_hash_chk u_chk (.*);

// ===== bench/tb.sv =====
// testbench for the sm3 stream hash: directed and random messages checked against a local model
`timescale 1ns / 100ps

module tb;
  import sm3_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last;

  sm3_stream_hash uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last(out_last)
  );

  // expected digest beat
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  digest_beat_t digest_q[$];

  // local hash state
  logic [31:0] chain[8];
  logic [7:0]  msg_buf[64];
  int unsigned fill;
  logic [54:0] nblocks;

  int errors;
  int send_idle_pct;
  int recv_idle_pct;

  localparam logic [31:0] H_INIT [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] p0f(logic [31:0] x);
    return x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic logic [31:0] p1f(logic [31:0] x);
    return x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

  // one compression of msg_buf into chain
  task automatic compress_block();
    logic [31:0] r[8];
    logic [31:0] w[68];
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj;
    for (int j = 0; j < 8; j++) r[j] = chain[j];
    for (int j = 0; j < 16; j++)
      w[j] = {msg_buf[4*j], msg_buf[4*j+1], msg_buf[4*j+2], msg_buf[4*j+3]};
    for (int j = 16; j < 68; j++)
      w[j] = p1f(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
    for (int j = 0; j < 64; j++) begin
      tj = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
      a12 = rol(r[0], 12);
      ss1 = rol(a12 + r[4] + rol(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = r[0] ^ r[1] ^ r[2];
        gg = r[4] ^ r[5] ^ r[6];
      end else begin
        ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
        gg = (r[4] & r[5]) | (~r[4] & r[6]);
      end
      tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + r[7] + ss1 + w[j];
      r[3] = r[2];
      r[2] = rol(r[1], 9);
      r[1] = r[0];
      r[0] = tt1;
      r[7] = r[6];
      r[6] = rol(r[5], 19);
      r[5] = r[4];
      r[4] = p0f(tt2);
    end
    for (int j = 0; j < 8; j++) chain[j] ^= r[j];
  endtask

  // advance the local model by one accepted beat
  task automatic hash_predict(logic kind, logic [7:0] data);
    logic [63:0] bitlen;
    digest_beat_t b;
    if (kind == KIND_BYTE) begin
      msg_buf[fill] = data;
      fill++;
      if (fill == 64) begin
        compress_block();
        nblocks++;
        fill = 0;
      end
      return;
    end
    bitlen = {nblocks, 9'd0} + 64'(fill * 8);
    msg_buf[fill] = PAD_BYTE;
    for (int k = fill + 1; k < 64; k++) msg_buf[k] = 8'h00;
    if (fill > 55) begin
      compress_block();
      for (int k = 0; k < 64; k++) msg_buf[k] = 8'h00;
    end
    for (int k = 0; k < 8; k++) msg_buf[56 + k] = bitlen[63 - 8*k -: 8];
    compress_block();
    for (int k = 0; k < 8; k++) begin
      b.word = chain[k];
      b.idx = 3'(k);
      b.last = (k == 7);
      digest_q.push_back(b);
    end
    for (int k = 0; k < 8; k++) chain[k] = H_INIT[k];
    fill = 0;
    nblocks = '0;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

  // receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    digest_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest beat, actual %h idx %0d last %0b",
                 $time, out_digest_word, out_word_index, out_last);
        errors++;
      end else begin
        e = digest_q.pop_front();
        if (out_digest_word !== e.word) begin
          $display("%0t: digest word mismatch, expected %h actual %h",
                   $time, e.word, out_digest_word);
          errors++;
        end
        if (out_word_index !== e.idx) begin
          $display("%0t: word index mismatch, expected %0d actual %0d",
                   $time, e.idx, out_word_index);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t: last flag mismatch, expected %0b actual %0b",
                   $time, e.last, out_last);
          errors++;
        end
      end
    end
  end

  // send one beat, with optional idle gaps before it; valid stays up after
  // the accepting edge until the next beat or an idle cycle replaces it
  task automatic send_beat(logic kind, logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hash_predict(kind, data);
  endtask

  task automatic send_message(int unsigned len);
    for (int unsigned k = 0; k < len; k++) send_beat(KIND_BYTE, 8'($urandom));
    send_beat(KIND_FINISH, 8'($urandom));
  endtask

  // directed: empty message, "abc", byte extremes
  task automatic test_directed();
    send_beat(KIND_FINISH, 8'hFF);
    send_beat(KIND_BYTE, 8'h61);
    send_beat(KIND_BYTE, 8'h62);
    send_beat(KIND_BYTE, 8'h63);
    send_beat(KIND_FINISH, 8'h00);
    send_beat(KIND_BYTE, 8'h00);
    send_beat(KIND_BYTE, 8'hFF);
    send_beat(KIND_BYTE, 8'hAA);
    send_beat(KIND_BYTE, 8'h55);
    send_beat(KIND_FINISH, 8'h5A);
  endtask

  // padding boundaries: 55/56 bytes split the tail, 64 fills a whole block
  task automatic test_pad_edges();
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);
    send_message(65);
  endtask

  // random messages, mostly short, some multi-block
  task automatic test_random(int unsigned beats);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < beats) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(20);
      send_message(len);
      sent += len + 1;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_BYTE;
    in_data_byte <= 8'h00;
    for (int k = 0; k < 8; k++) chain[k] = H_INIT[k];
    fill = 0;
    nblocks = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // light sender gaps, heavy receiver stalls
    send_idle_pct = 6;
    recv_idle_pct = 45;
    test_directed();
    test_pad_edges();
    test_random(35);
    // heavy sender gaps, light receiver stalls
    send_idle_pct = 45;
    recv_idle_pct = 6;
    test_random(35);
    // full speed
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(35);
    drain();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
